>>> design/tsph_pkg.sv
// ----------------------------------------------------------------------------
// tsph_pkg
// Shared types, constants and the midpoint split function for the sphere
// subdivision unit.
// ----------------------------------------------------------------------------
package tsph_pkg;

    localparam int LEVELS    = 2;
    localparam int FRAC_BITS = 16;

    localparam int CW       = FRAC_BITS + 2;     // coordinate width
    localparam int RW       = FRAC_BITS + 1;     // radius width
    localparam int SQ_W     = 2 * CW;            // squared length width
    localparam int DIV_W    = 2 * CW;            // dividend / quotient width
    localparam int FIN_W    = DIV_W + 2;         // signed result before clamp
    localparam int IDX_W    = 20;
    localparam int NSUB     = 4 ** LEVELS;
    localparam int SUB_W    = 2 * LEVELS;
    localparam int LVL_W    = $clog2(LEVELS + 1);
    localparam int SQRT_W   = $clog2(CW + 1);
    localparam int DIVC_W   = $clog2(DIV_W + 1);
    localparam int IN_W     = ((9 * CW + 7) / 8) * 8;
    localparam int OUT_W    = ((9 * CW + IDX_W + 7) / 8) * 8;
    localparam int CFG_W    = CW;

    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_OFFSET_X = 2'd1;
    localparam logic [1:0] REG_OFFSET_Y = 2'd2;

    typedef logic signed [CW-1:0] coord_t;

    // one sub-triangle: c[0..2] = a xyz, c[3..5] = b xyz, c[6..8] = c xyz
    typedef struct packed {
        coord_t [8:0] c;
        logic         last;
    } tri_t;

    typedef struct packed {
        logic [RW-1:0] radius;
        coord_t        offset_x;
        coord_t        offset_y;
    } cfg_t;

    function automatic coord_t mid(coord_t p, coord_t q);
        logic signed [CW:0] s;
        s = {p[CW-1], p} + {q[CW-1], q};
        return coord_t'(s >>> 1);
    endfunction

    // child d of (v1,v2,v3): (v1,n1,n3) (n1,v2,n2) (n1,n2,n3) (n3,n2,v3)
    function automatic tri_t child(tri_t t, logic [1:0] d);
        tri_t r;
        coord_t [2:0] n1, n2, n3, v1, v2, v3;
        for (int k = 0; k < 3; k++)
        begin
            v1[k] = t.c[k];
            v2[k] = t.c[3 + k];
            v3[k] = t.c[6 + k];
            n1[k] = mid(v1[k], v2[k]);
            n2[k] = mid(v2[k], v3[k]);
            n3[k] = mid(v1[k], v3[k]);
        end
        r = t;
        for (int k = 0; k < 3; k++)
        begin
            unique case (d)
                2'd0:
                begin
                    r.c[k] = v1[k]; r.c[3 + k] = n1[k]; r.c[6 + k] = n3[k];
                end
                2'd1:
                begin
                    r.c[k] = n1[k]; r.c[3 + k] = v2[k]; r.c[6 + k] = n2[k];
                end
                2'd2:
                begin
                    r.c[k] = n1[k]; r.c[3 + k] = n2[k]; r.c[6 + k] = n3[k];
                end
                default:
                begin
                    r.c[k] = n3[k]; r.c[3 + k] = n2[k]; r.c[6 + k] = v3[k];
                end
            endcase
        end
        return r;
    endfunction

endpackage

>>> design/tsph_front.sv
// ----------------------------------------------------------------------------
// tsph_front
// Accepts a triangle and walks its sub-triangles in order, one split level
// per cycle, pushing each finished sub-triangle into the queue.
// ----------------------------------------------------------------------------
module tsph_front
    import tsph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tri_t             in_tri,
    output logic             push,
    output tri_t             push_tri,
    input  logic             q_full
);

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_LOAD  = 4'b0010,
        F_SPLIT = 4'b0100,
        F_PUSH  = 4'b1000
    } fstate_t;

    fstate_t           state_reg, state_next;
    tri_t              root_reg, root_next;
    tri_t              work_reg, work_next;
    logic [SUB_W-1:0]  sub_reg, sub_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [1:0]        digit;
    logic              is_last;

    assign in_ready = (state_reg == F_IDLE);
    assign is_last  = (sub_reg == SUB_W'(NSUB - 1));
    assign digit    = sub_reg[2 * (LEVELS - 1 - int'(lvl_reg)) +: 2];
    assign push     = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        push_tri      = work_reg;
        push_tri.last = is_last;
    end

    always_comb
    begin
        state_next = state_reg;
        root_next  = root_reg;
        work_next  = work_reg;
        sub_next   = sub_reg;
        lvl_next   = lvl_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    root_next  = in_tri;
                    sub_next   = '0;
                    state_next = F_LOAD;
                end
            end
            F_LOAD:
            begin
                work_next  = root_reg;
                lvl_next   = '0;
                state_next = F_SPLIT;
            end
            F_SPLIT:
            begin
                work_next = child(work_reg, digit);
                lvl_next  = lvl_reg + 1'b1;
                if (lvl_reg == LVL_W'(LEVELS - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    if (is_last)
                        state_next = F_IDLE;
                    else
                    begin
                        sub_next   = sub_reg + 1'b1;
                        state_next = F_LOAD;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            sub_reg   <= '0;
            lvl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            lvl_reg   <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
        work_reg <= work_next;
    end

endmodule

>>> design/tsph_queue.sv
// ----------------------------------------------------------------------------
// tsph_queue
// Two-entry queue of sub-triangles between the splitter and the normalizer.
// ----------------------------------------------------------------------------
module tsph_queue
    import tsph_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tri_t push_tri,
    output logic full,
    input  logic pop,
    output tri_t pop_tri,
    output logic empty
);

    tri_t [1:0]  mem_reg;
    logic        wr_reg, rd_reg;
    logic [1:0]  cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_tri = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_tri;
    end

endmodule

>>> design/tsph_back.sv
// ----------------------------------------------------------------------------
// tsph_back
// Rescales each vertex of a sub-triangle to the sphere radius with two
// multipliers, a bit-serial square root and a bit-serial divider,
// then applies the offsets, clamps and drives the output register.
// ----------------------------------------------------------------------------
module tsph_back
    import tsph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             q_empty,
    input  tri_t             q_tri,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output coord_t [8:0]     out_coord,
    output logic [IDX_W-1:0] out_index,
    output logic             out_last,
    output logic             out_degen
);

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_SQ   = 7'b0000010,
        B_SQRT = 7'b0000100,
        B_MUL  = 7'b0001000,
        B_DIV  = 7'b0010000,
        B_FIN  = 7'b0100000,
        B_OUT  = 7'b1000000
    } bstate_t;

    bstate_t            state_reg;
    tri_t               tri_reg;
    coord_t [8:0]       res_reg;
    logic [1:0]         vi_reg, ci_reg;
    logic [SQ_W-1:0]    acc_reg;
    logic [CW+1:0]      srem_reg;
    logic [CW-1:0]      len_reg;
    logic [SQRT_W-1:0]  step_reg;
    logic [DIVC_W-1:0]  dstep_reg;
    logic [DIV_W-1:0]   nq_reg;
    logic [CW-1:0]      drem_reg;
    logic               neg_reg;
    logic               degen_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    coord_t [8:0]       out_coord_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic               out_last_reg;
    logic               out_degen_reg;

    coord_t                 cur;
    logic [CW-1:0]          cur_abs;
    logic signed [SQ_W-1:0] sq;
    logic [CW+3:0]          srem_s;
    logic [CW+3:0]          trial;
    logic [CW:0]            drem_s;
    logic [CW+RW-1:0]       prod;
    logic signed [FIN_W-1:0] fval, fofs, fsum;
    coord_t                 fsat;
    logic                   out_free;

    localparam logic signed [FIN_W-1:0] SAT_HI = (FIN_W'(1) <<< (FRAC_BITS + 1)) - 1;
    localparam logic signed [FIN_W-1:0] SAT_LO = -(FIN_W'(1) <<< (FRAC_BITS + 1));

    assign cur      = tri_reg.c[4'(vi_reg) * 4'd3 + 4'(ci_reg)];
    assign cur_abs  = cur[CW-1] ? CW'(-cur) : CW'(cur);
    assign sq       = cur * cur;
    assign srem_s   = {srem_reg, acc_reg[SQ_W-1 -: 2]};
    assign trial    = {2'b00, len_reg, 2'b01};
    assign drem_s   = {drem_reg, nq_reg[DIV_W-1]};
    assign prod     = cur_abs * cfg.radius;
    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        fval = FIN_W'($signed({2'b00, nq_reg}));
        if (neg_reg)
            fval = -fval;
        unique case (ci_reg)
            2'd0:    fofs = FIN_W'(cfg.offset_x);
            2'd1:    fofs = -FIN_W'(cfg.offset_y);
            default: fofs = '0;
        endcase
        fsum = fval + fofs;
        priority if (fsum > SAT_HI)
            fsat = coord_t'(SAT_HI);
        else if (fsum < SAT_LO)
            fsat = coord_t'(SAT_LO);
        else
            fsat = coord_t'(fsum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            vi_reg        <= '0;
            ci_reg        <= '0;
            step_reg      <= '0;
            dstep_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in B_OUT the valid flag is handled by the state arm below
            if (out_valid_reg && out_ready && state_reg != B_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        vi_reg    <= '0;
                        ci_reg    <= '0;
                        state_reg <= B_SQ;
                    end
                end
                B_SQ:
                begin
                    if (ci_reg == 2'd2)
                    begin
                        ci_reg    <= '0;
                        step_reg  <= '0;
                        state_reg <= B_SQRT;
                    end
                    else
                        ci_reg <= ci_reg + 2'd1;
                end
                B_SQRT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SQRT_W'(CW - 1))
                        state_reg <= B_MUL;
                end
                B_MUL:
                begin
                    dstep_reg <= '0;
                    state_reg <= (len_reg == '0) ? B_FIN : B_DIV;
                end
                B_DIV:
                begin
                    dstep_reg <= dstep_reg + 1'b1;
                    if (dstep_reg == DIVC_W'(DIV_W - 1))
                        state_reg <= B_FIN;
                end
                B_FIN:
                begin
                    if (ci_reg != 2'd2)
                    begin
                        ci_reg    <= ci_reg + 2'd1;
                        state_reg <= B_MUL;
                    end
                    else if (vi_reg != 2'd2)
                    begin
                        ci_reg    <= '0;
                        vi_reg    <= vi_reg + 2'd1;
                        state_reg <= B_SQ;
                    end
                    else
                        state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        cnt_reg       <= cnt_reg + 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    tri_reg   <= q_tri;
                    acc_reg   <= '0;
                    degen_reg <= 1'b0;
                end
            end
            B_SQ:
            begin
                acc_reg  <= acc_reg + SQ_W'(sq);
                srem_reg <= '0;
                len_reg  <= '0;
            end
            B_SQRT:
            begin
                acc_reg <= acc_reg << 2;
                if (srem_s >= trial)
                begin
                    srem_reg <= (CW+2)'(srem_s - trial);
                    len_reg  <= {len_reg[CW-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_s[CW+1:0];
                    len_reg  <= {len_reg[CW-2:0], 1'b0};
                end
            end
            B_MUL:
            begin
                nq_reg   <= (len_reg == '0) ? '0
                            : DIV_W'(prod) + DIV_W'(len_reg >> 1);
                neg_reg  <= cur[CW-1];
                drem_reg <= '0;
                if (len_reg == '0)
                    degen_reg <= 1'b1;
            end
            B_DIV:
            begin
                if (drem_s >= {1'b0, len_reg})
                begin
                    drem_reg <= CW'(drem_s - {1'b0, len_reg});
                    nq_reg   <= {nq_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_s[CW-1:0];
                    nq_reg   <= {nq_reg[DIV_W-2:0], 1'b0};
                end
            end
            B_FIN:
            begin
                res_reg[4'(vi_reg) * 4'd3 + 4'(ci_reg)] <= fsat;
                if (ci_reg == 2'd2)
                    acc_reg <= '0;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    out_coord_reg <= res_reg;
                    out_index_reg <= cnt_reg + (cnt_reg << 1);
                    out_last_reg  <= tri_reg.last;
                    out_degen_reg <= degen_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_coord = out_coord_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;
    assign out_degen = out_degen_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DIV |-> len_reg != '0)
        else $error("divide started with zero length");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == B_SQ && vi_reg == 2'd0 && ci_reg == 2'd0)
        else $error("pop did not start a new triangle");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_OUT && out_free |=> out_valid_reg && state_reg == B_IDLE)
        else $error("result not presented");

endmodule

>>> design/triangle_subdivide_to_sphere_unit.sv
// ----------------------------------------------------------------------------
// triangle_subdivide_to_sphere_unit
// Splits one triangle into 4^LEVELS sub-triangles and projects every vertex
// onto a sphere of configurable radius with x/y offsets.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one input triangle per item (three Q1.16 vertices).
//   m_axis gives 4^LEVELS result items per input, tlast on the final one,
//   tuser set when a vertex had zero length.
//   cfg_we/cfg_index/cfg_data write radius, offset_x, offset_y while idle.
// Timing:
//   A splitter walks the sub-triangles into a two-entry queue; the
//   normalizer handles one vertex at a time on two multipliers, an
//   18-step square root and a 36-step divider. The divider sets the rate.
//   A new input is taken once the splitter has queued the last sub-triangle
//   of the previous one.
// Reset: clears control state, radius = 1.0, offsets = 0, index counter 0.
// Stall: the result register holds while m_axis_tready is low; the
//   normalizer and then the splitter stop behind it.
// ----------------------------------------------------------------------------
module triangle_subdivide_to_sphere_unit
    import tsph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // out_ax .. out_cz, first_vertex_index, zero pad
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast,
    // degenerate
    output logic             m_axis_tuser,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t             cfg_reg;
    tri_t             in_tri;
    tri_t             push_tri, pop_tri;
    logic             push, pop, q_full, q_empty;
    coord_t [8:0]     out_coord;
    logic [IDX_W-1:0] out_index;

    always_comb
    begin
        in_tri.last = 1'b0;
        for (int i = 0; i < 9; i++)
            in_tri.c[i] = coord_t'(s_axis_tdata[i * CW +: CW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius   <= RW'(1) << FRAC_BITS;
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS:   cfg_reg.radius   <= cfg_data[RW-1:0];
                REG_OFFSET_X: cfg_reg.offset_x <= coord_t'(cfg_data);
                REG_OFFSET_Y: cfg_reg.offset_y <= coord_t'(cfg_data);
                default: ;
            endcase
        end
    end

    tsph_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_tri   (in_tri),
        .push     (push),
        .push_tri (push_tri),
        .q_full   (q_full)
    );

    tsph_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tri (push_tri),
        .full     (q_full),
        .pop      (pop),
        .pop_tri  (pop_tri),
        .empty    (q_empty)
    );

    tsph_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_tri     (pop_tri),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_coord (out_coord),
        .out_index (out_index),
        .out_last  (m_axis_tlast),
        .out_degen (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'({out_index, out_coord});

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sphere subdivision unit: directed and random triangles are
// split and projected by a local predictor, every result item is compared
// field by field; radius and offsets are changed between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import tsph_pkg::*;

    typedef struct {
        logic [CW-1:0] c [9];
        logic [IDX_W-1:0] vidx;
        logic last;
        logic degen;
    } sub_res_t;

    typedef struct {
        logic [CW-1:0] v [9];
    } tri_in_t;

    logic clk = 0;
    logic rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic m_axis_tuser;
    logic cfg_we = 0;
    logic [1:0] cfg_index = REG_RADIUS;
    logic [CFG_W-1:0] cfg_data = '0;

    triangle_subdivide_to_sphere_unit DUT (.*);

    always #2 clk = ~clk;

    tri_in_t pend_tris [$];
    sub_res_t exp_subs [$];
    int errors = 0;
    int accepted = 0;
    int total_items = 0;

    // predictor state
    longint pr_radius = 65536;
    longint pr_offx = 0;
    longint pr_offy = 0;
    logic [IDX_W-1:0] pr_tri_count = 0;

    function automatic longint sx(logic [CW-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint halfdown(longint s);
        return s >>> 1;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r = 0;
        longint b = 64'sd1 << 60;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clamp_q2(longint v);
        longint hi = (64'sd1 << (FRAC_BITS + 1)) - 1;
        longint lo = -(64'sd1 << (FRAC_BITS + 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // projects one vertex; returns 1 on zero length
    function automatic bit project(input longint p [3], output longint o [3]);
        longint l2 = 0, len, n [3], mag, q;
        for (int k = 0; k < 3; k++)
        begin
            l2 += p[k] * p[k];
            n[k] = 0;
        end
        len = int_sqrt(l2);
        if (len != 0)
            for (int k = 0; k < 3; k++)
            begin
                mag = (p[k] < 0 ? -p[k] : p[k]) * pr_radius;
                q = (mag + len / 2) / len;
                n[k] = p[k] < 0 ? -q : q;
            end
        o[0] = clamp_q2(n[0] + pr_offx);
        o[1] = clamp_q2(n[1] - pr_offy);
        o[2] = clamp_q2(n[2]);
        return len == 0;
    endfunction

    task automatic predict_sphere_tris(tri_in_t t);
        longint cur [$][9];
        longint nxt [$][9];
        longint a [9], p [3], o [3], m1 [3], m2 [3], m3 [3];
        sub_res_t r;
        for (int i = 0; i < 9; i++) a[i] = sx(t.v[i]);
        cur.push_back(a);
        for (int l = 0; l < LEVELS; l++)
        begin
            nxt.delete();
            foreach (cur[i])
            begin
                a = cur[i];
                for (int k = 0; k < 3; k++)
                begin
                    m1[k] = halfdown(a[k] + a[3 + k]);
                    m2[k] = halfdown(a[3 + k] + a[6 + k]);
                    m3[k] = halfdown(a[k] + a[6 + k]);
                end
                for (int d = 0; d < 4; d++)
                begin
                    longint s [9];
                    for (int k = 0; k < 3; k++)
                    begin
                        case (d)
                            0: begin s[k] = a[k]; s[3+k] = m1[k]; s[6+k] = m3[k]; end
                            1: begin s[k] = m1[k]; s[3+k] = a[3+k]; s[6+k] = m2[k]; end
                            2: begin s[k] = m1[k]; s[3+k] = m2[k]; s[6+k] = m3[k]; end
                            default: begin s[k] = m3[k]; s[3+k] = m2[k]; s[6+k] = a[6+k]; end
                        endcase
                    end
                    nxt.push_back(s);
                end
            end
            cur = nxt;
        end
        foreach (cur[i])
        begin
            r.degen = 0;
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++) p[k] = cur[i][j * 3 + k];
                if (project(p, o)) r.degen = 1;
                for (int k = 0; k < 3; k++) r.c[j * 3 + k] = o[k][CW-1:0];
            end
            r.vidx = IDX_W'(pr_tri_count * 3);
            r.last = (i == cur.size() - 1);
            pr_tri_count = pr_tri_count + 1;
            exp_subs.push_back(r);
        end
    endtask

    // driver
    int in_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                accepted <= accepted + 1;
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (s_axis_tvalid && s_axis_tready)
                    in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
                if (in_gap > 0 || pend_tris.size() == 0)
                begin
                    s_axis_tvalid <= 0;
                    if (in_gap > 0) in_gap--;
                end
                else
                begin
                    tri_in_t t;
                    logic [IN_W-1:0] d;
                    t = pend_tris.pop_front();
                    d = '0;
                    for (int i = 0; i < 9; i++) d[i * CW +: CW] = t.v[i];
                    predict_sphere_tris(t);
                    s_axis_tdata <= d;
                    s_axis_tvalid <= 1;
                end
            end
        end
    end

    // monitor
    int out_stall = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                sub_res_t e;
                if (exp_subs.size() == 0)
                begin
                    $display("%0t unexpected result item %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    e = exp_subs.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (m_axis_tdata[i * CW +: CW] !== e.c[i])
                        begin
                            $display("%0t coord %0d exp %h got %h", $time, i, e.c[i],
                                     m_axis_tdata[i * CW +: CW]);
                            errors++;
                        end
                    if (m_axis_tdata[9 * CW +: IDX_W] !== e.vidx)
                    begin
                        $display("%0t index exp %h got %h", $time, e.vidx,
                                 m_axis_tdata[9 * CW +: IDX_W]);
                        errors++;
                    end
                    if (m_axis_tlast !== e.last)
                    begin
                        $display("%0t last exp %b got %b", $time, e.last, m_axis_tlast);
                        errors++;
                    end
                    if (m_axis_tuser !== e.degen)
                    begin
                        $display("%0t degenerate exp %b got %b", $time, e.degen,
                                 m_axis_tuser);
                        errors++;
                    end
                end
                out_stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            end
            if (out_stall > 0)
            begin
                m_axis_tready <= 0;
                out_stall--;
            end
            else
                m_axis_tready <= 1;
        end
    end

    function automatic logic [CW-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return CW'(65536);
            1: return CW'(-65536);
            2: return CW'($urandom_range(0, 16));
            3: return CW'($urandom);
            default: return CW'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    task automatic add_tri(longint a0, a1, a2, b0, b1, b2, c0, c1, c2);
        tri_in_t t;
        longint q [9];
        q = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        for (int i = 0; i < 9; i++) t.v[i] = q[i][CW-1:0];
        pend_tris.push_back(t);
        total_items++;
    endtask

    task automatic write_reg(logic [1:0] idx, longint v);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            REG_RADIUS: pr_radius = longint'(v[RW-1:0]);
            REG_OFFSET_X: pr_offx = sx(v[CW-1:0]);
            REG_OFFSET_Y: pr_offy = sx(v[CW-1:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pend_tris.size() == 0 && accepted == total_items && exp_subs.size() == 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic random_tris(int n);
        tri_in_t t;
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < 9; k++) t.v[k] = rnd_coord();
            pend_tris.push_back(t);
            total_items++;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        // directed: unit axes, extremes, zero vertex, all zero, wrapped patterns
        add_tri(65536, 0, 0, 0, 65536, 0, 0, 0, 65536);
        add_tri(-65536, -65536, -65536, 65536, 65536, 65536, -65536, 65536, -65536);
        add_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0);
        add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_tri(1, 0, 0, -1, 0, 0, 0, 1, -1);
        add_tri(131071, -131072, 131071, -131072, 131071, -131072, 1, 1, 1);
        add_tri(-1, -1, -1, -1, -1, -1, 65535, -65535, 3);
        drain();
        write_reg(REG_RADIUS, 0);
        write_reg(REG_OFFSET_X, 65536);
        write_reg(REG_OFFSET_Y, -65536);
        add_tri(65536, 0, 0, 0, 65536, 0, 0, 0, 65536);
        add_tri(0, 0, 0, 1, 1, 1, -1, -1, -1);
        random_tris(60);
        drain();
        write_reg(REG_RADIUS, 65536);
        write_reg(REG_OFFSET_X, 65536);
        write_reg(REG_OFFSET_Y, -65536);
        add_tri(65536, 65536, 0, 0, -65536, 0, 0, 0, 65536);
        random_tris(100);
        drain();
        write_reg(REG_RADIUS, 131071);
        write_reg(REG_OFFSET_X, -65536);
        write_reg(REG_OFFSET_Y, 65536);
        random_tris(60);
        drain();
        write_reg(REG_OFFSET_X, 262143);
        write_reg(REG_OFFSET_Y, 131072);
        write_reg(REG_RADIUS, $urandom_range(0, 65536));
        random_tris(60);
        drain();
        write_reg(REG_RADIUS, 65536);
        write_reg(REG_OFFSET_X, 0);
        write_reg(REG_OFFSET_Y, 0);
        random_tris(60);
        drain();
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
